### rtl/sohit_pkg.sv
// Shared types, constants and the micro-program for the segment obstacle hit test.
package sohit_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned DIFF_W  = COORD_W + 1;
  localparam int unsigned LIMB_W  = 34;
  localparam int unsigned OPND_W  = LIMB_W + 1;
  localparam int unsigned PROD_W  = 2 * OPND_W;
  localparam int unsigned WIDE_W  = 2 * LIMB_W;
  localparam int unsigned ACC_W   = 140;
  localparam int unsigned STEP_W  = 5;
  localparam int unsigned NUM_PT  = 10;

  // Result kinds
  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_SKIP  = 2'd1;
  localparam logic [1:0] KIND_CROSS = 2'd2;
  localparam logic [1:0] KIND_NEAR  = 2'd3;

  // Micro-program steps at which the sequencer acts on the accumulator
  localparam logic [STEP_W-1:0] STEP_SIDE_F = 5'd1;
  localparam logic [STEP_W-1:0] STEP_SIDE_S = 5'd3;
  localparam logic [STEP_W-1:0] STEP_SEG_E  = 5'd5;
  localparam logic [STEP_W-1:0] STEP_SEG_N  = 5'd7;
  localparam logic [STEP_W-1:0] STEP_DOT    = 5'd9;
  localparam logic [STEP_W-1:0] STEP_LEN2   = 5'd11;
  localparam logic [STEP_W-1:0] STEP_REM    = 5'd13;
  localparam logic [STEP_W-1:0] STEP_CROSS  = 5'd15;
  localparam logic [STEP_W-1:0] STEP_MARG2  = 5'd16;
  localparam logic [STEP_W-1:0] STEP_LAST   = 5'd24;

  localparam logic [1:0] PH_CHECK = 2'd3;

  typedef enum logic [3:0] {
    PT_ZERO, PT_FX, PT_FZ, PT_SX, PT_SZ, PT_EX, PT_EZ, PT_NX, PT_NZ, PT_M
  } pt_e;

  typedef enum logic [2:0] {
    LB_NONE, LB_CR_LO, LB_CR_HI, LB_M2_LO, LB_M2_HI, LB_L2_LO, LB_L2_HI
  } limb_e;

  typedef enum logic [1:0] {ACC_LOAD, ACC_ADD, ACC_SUB} acc_op_e;

  typedef enum logic [1:0] {CAP_NONE, CAP_L2, CAP_CR, CAP_M2} cap_e;

  typedef struct packed {
    pt_e   p;
    pt_e   q;
    limb_e limb;
  } opnd_t;

  typedef struct packed {
    opnd_t     a;
    opnd_t     b;
    logic [1:0] shift;
    acc_op_e   op;
  } uop_t;

  typedef struct packed {
    logic        busy;
    logic [1:0]  phase;
    logic [1:0]  edge_idx;
    uop_t        uop;
    cap_e        cap;
  } dp_ctrl_t;

  typedef struct packed {
    logic acc_neg;
    logic acc_zero;
    logic end_inside;
    logic zero_len;
    logic m_pos;
    logic e_at_f;
  } dp_stat_t;

  typedef struct packed {
    logic [COORD_W-1:0] first_x;
    logic [COORD_W-1:0] first_z;
    logic [COORD_W-1:0] second_x;
    logic [COORD_W-1:0] second_z;
    logic [COORD_W-1:0] clearance;
    logic [COORD_W-1:0] rect_min_x;
    logic [COORD_W-1:0] rect_min_z;
    logic [COORD_W-1:0] rect_max_x;
    logic [COORD_W-1:0] rect_max_z;
    logic               last_rect;
  } in_item_t;

  typedef struct packed {
    logic [1:0] hit_kind;
    logic       any_hit;
    logic       list_done;
  } out_item_t;

  function automatic opnd_t dif(pt_e p, pt_e q);
    opnd_t o;
    o.p = p;
    o.q = q;
    o.limb = LB_NONE;
    return o;
  endfunction

  function automatic opnd_t lmb(limb_e l);
    opnd_t o;
    o.p = PT_ZERO;
    o.q = PT_ZERO;
    o.limb = l;
    return o;
  endfunction

  function automatic uop_t mk(opnd_t a, opnd_t b, logic [1:0] sh, acc_op_e op);
    uop_t u;
    u.a = a;
    u.b = b;
    u.shift = sh;
    u.op = op;
    return u;
  endfunction

  // One multiply-accumulate per step; E/N are the current edge's start/end
  function automatic uop_t step_uop(logic [STEP_W-1:0] s);
    uop_t u;
    case (s)
      5'd0:    u = mk(dif(PT_NX, PT_EX), dif(PT_FZ, PT_EZ), 2'd0, ACC_LOAD);
      5'd1:    u = mk(dif(PT_NZ, PT_EZ), dif(PT_FX, PT_EX), 2'd0, ACC_SUB);
      5'd2:    u = mk(dif(PT_NX, PT_EX), dif(PT_SZ, PT_EZ), 2'd0, ACC_LOAD);
      5'd3:    u = mk(dif(PT_NZ, PT_EZ), dif(PT_SX, PT_EX), 2'd0, ACC_SUB);
      5'd4:    u = mk(dif(PT_SX, PT_FX), dif(PT_EZ, PT_FZ), 2'd0, ACC_LOAD);
      5'd5:    u = mk(dif(PT_SZ, PT_FZ), dif(PT_EX, PT_FX), 2'd0, ACC_SUB);
      5'd6:    u = mk(dif(PT_SX, PT_FX), dif(PT_NZ, PT_FZ), 2'd0, ACC_LOAD);
      5'd7:    u = mk(dif(PT_SZ, PT_FZ), dif(PT_NX, PT_FX), 2'd0, ACC_SUB);
      5'd8:    u = mk(dif(PT_EX, PT_FX), dif(PT_SX, PT_FX), 2'd0, ACC_LOAD);
      5'd9:    u = mk(dif(PT_EZ, PT_FZ), dif(PT_SZ, PT_FZ), 2'd0, ACC_ADD);
      5'd10:   u = mk(dif(PT_SX, PT_FX), dif(PT_SX, PT_FX), 2'd0, ACC_LOAD);
      5'd11:   u = mk(dif(PT_SZ, PT_FZ), dif(PT_SZ, PT_FZ), 2'd0, ACC_ADD);
      5'd12:   u = mk(dif(PT_EX, PT_FX), dif(PT_SX, PT_FX), 2'd0, ACC_SUB);
      5'd13:   u = mk(dif(PT_EZ, PT_FZ), dif(PT_SZ, PT_FZ), 2'd0, ACC_SUB);
      5'd14:   u = mk(dif(PT_EX, PT_FX), dif(PT_FZ, PT_SZ), 2'd0, ACC_LOAD);
      5'd15:   u = mk(dif(PT_EZ, PT_FZ), dif(PT_FX, PT_SX), 2'd0, ACC_SUB);
      5'd16:   u = mk(dif(PT_M, PT_ZERO), dif(PT_M, PT_ZERO), 2'd0, ACC_LOAD);
      5'd17:   u = mk(lmb(LB_CR_LO), lmb(LB_CR_LO), 2'd0, ACC_LOAD);
      5'd18:   u = mk(lmb(LB_CR_LO), lmb(LB_CR_HI), 2'd1, ACC_ADD);
      5'd19:   u = mk(lmb(LB_CR_HI), lmb(LB_CR_LO), 2'd1, ACC_ADD);
      5'd20:   u = mk(lmb(LB_CR_HI), lmb(LB_CR_HI), 2'd2, ACC_ADD);
      5'd21:   u = mk(lmb(LB_M2_LO), lmb(LB_L2_LO), 2'd0, ACC_SUB);
      5'd22:   u = mk(lmb(LB_M2_LO), lmb(LB_L2_HI), 2'd1, ACC_SUB);
      5'd23:   u = mk(lmb(LB_M2_HI), lmb(LB_L2_LO), 2'd1, ACC_SUB);
      default: u = mk(lmb(LB_M2_HI), lmb(LB_L2_HI), 2'd2, ACC_SUB);
    endcase
    return u;
  endfunction

endpackage

### rtl/sohit_if.sv
// Valid/ready channel interfaces for input items and results.
interface sohit_in_if import sohit_pkg::*; ;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sohit_out_if import sohit_pkg::*; ;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/sohit_dp.sv
// Datapath: item store, operand select, shared multiply-accumulate and wide captures.
module sohit_dp import sohit_pkg::*; (
  input  logic     clk_i,
  input  logic     load_i,
  input  in_item_t item_i,
  input  dp_ctrl_t ctrl_i,
  output dp_stat_t stat_o
);

  in_item_t                  item_q;
  logic signed [OPND_W-1:0]  opa_q, opb_q, opa_d, opb_d;
  logic signed [PROD_W-1:0]  prod_q, prod_d;
  logic signed [ACC_W-1:0]   acc_q, acc_d, addend, prod_ext, acc_neg_val;
  logic [WIDE_W-1:0]         l2_q, cr_q, m2_q;
  logic signed [COORD_W-1:0] coord [NUM_PT];
  logic [1:0]                n_idx;

  // Corner positions of the current edge
  assign n_idx = ctrl_i.edge_idx + 2'd1;

  always_comb begin
    coord[PT_ZERO] = '0;
    coord[PT_FX]   = $signed(item_q.first_x);
    coord[PT_FZ]   = $signed(item_q.first_z);
    coord[PT_SX]   = $signed(item_q.second_x);
    coord[PT_SZ]   = $signed(item_q.second_z);
    coord[PT_EX]   = (ctrl_i.edge_idx[0] ^ ctrl_i.edge_idx[1]) ?
                     $signed(item_q.rect_max_x) : $signed(item_q.rect_min_x);
    coord[PT_EZ]   = ctrl_i.edge_idx[1] ?
                     $signed(item_q.rect_max_z) : $signed(item_q.rect_min_z);
    coord[PT_NX]   = (n_idx[0] ^ n_idx[1]) ?
                     $signed(item_q.rect_max_x) : $signed(item_q.rect_min_x);
    coord[PT_NZ]   = n_idx[1] ? $signed(item_q.rect_max_z) : $signed(item_q.rect_min_z);
    coord[PT_M]    = $signed(item_q.clearance);
  end

  function automatic logic signed [OPND_W-1:0] form(
    opnd_t o, logic signed [COORD_W-1:0] pv, logic signed [COORD_W-1:0] qv,
    logic [WIDE_W-1:0] cr, logic [WIDE_W-1:0] m2, logic [WIDE_W-1:0] l2);
    logic signed [DIFF_W-1:0] d;
    logic signed [OPND_W-1:0] r;
    d = DIFF_W'(pv) - DIFF_W'(qv);
    case (o.limb)
      LB_CR_LO: r = {1'b0, cr[LIMB_W-1:0]};
      LB_CR_HI: r = {1'b0, cr[WIDE_W-1:LIMB_W]};
      LB_M2_LO: r = {1'b0, m2[LIMB_W-1:0]};
      LB_M2_HI: r = {1'b0, m2[WIDE_W-1:LIMB_W]};
      LB_L2_LO: r = {1'b0, l2[LIMB_W-1:0]};
      LB_L2_HI: r = {1'b0, l2[WIDE_W-1:LIMB_W]};
      default:  r = OPND_W'(d);
    endcase
    return r;
  endfunction

  assign opa_d = form(ctrl_i.uop.a, coord[ctrl_i.uop.a.p], coord[ctrl_i.uop.a.q],
                      cr_q, m2_q, l2_q);
  assign opb_d = form(ctrl_i.uop.b, coord[ctrl_i.uop.b.p], coord[ctrl_i.uop.b.q],
                      cr_q, m2_q, l2_q);
  assign prod_d = opa_q * opb_q;

  // Align the product to its limb position and accumulate
  assign prod_ext = ACC_W'(prod_q);
  always_comb begin
    case (ctrl_i.uop.shift)
      2'd0:    addend = prod_ext;
      2'd1:    addend = prod_ext <<< LIMB_W;
      default: addend = prod_ext <<< (2 * LIMB_W);
    endcase
    case (ctrl_i.uop.op)
      ACC_ADD: acc_d = acc_q + addend;
      ACC_SUB: acc_d = acc_q - addend;
      default: acc_d = addend;
    endcase
  end

  assign acc_neg_val = -acc_q;

  // Hold the item; step the unit through its phases
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
    if (ctrl_i.busy) begin
      case (ctrl_i.phase)
        2'd0: begin
          opa_q <= opa_d;
          opb_q <= opb_d;
        end
        2'd1: prod_q <= prod_d;
        2'd2: acc_q <= acc_d;
        default: begin
          case (ctrl_i.cap)
            CAP_L2: l2_q <= acc_q[WIDE_W-1:0];
            CAP_CR: cr_q <= acc_q[ACC_W-1] ? acc_neg_val[WIDE_W-1:0] : acc_q[WIDE_W-1:0];
            CAP_M2: m2_q <= acc_q[WIDE_W-1:0];
            default: ;
          endcase
        end
      endcase
    end
  end

  // Status towards the sequencer
  always_comb begin
    stat_o.acc_neg    = acc_q[ACC_W-1];
    stat_o.acc_zero   = (acc_q == '0);
    stat_o.end_inside =
      (coord[PT_FX] > $signed(item_q.rect_min_x) && coord[PT_FZ] > $signed(item_q.rect_min_z) &&
       coord[PT_FX] < $signed(item_q.rect_max_x) && coord[PT_FZ] < $signed(item_q.rect_max_z)) ||
      (coord[PT_SX] > $signed(item_q.rect_min_x) && coord[PT_SZ] > $signed(item_q.rect_min_z) &&
       coord[PT_SX] < $signed(item_q.rect_max_x) && coord[PT_SZ] < $signed(item_q.rect_max_z));
    stat_o.zero_len   = (item_q.first_x == item_q.second_x) &&
                        (item_q.first_z == item_q.second_z);
    stat_o.m_pos      = coord[PT_M] > $signed(COORD_W'(0));
    stat_o.e_at_f     = (coord[PT_EX] == coord[PT_FX]) && (coord[PT_EZ] == coord[PT_FZ]);
  end

endmodule

### rtl/sohit_seq.sv
// Sequencer: walks the edges and the micro-program, decides the hit kind.
module sohit_seq import sohit_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic       out_free_i,
  input  dp_stat_t   stat_i,
  output logic       ready_o,
  output logic       done_o,
  output logic [1:0] kind_o,
  output dp_ctrl_t   ctrl_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_INSIDE = 2'd1;
  localparam logic [1:0] S_RUN    = 2'd2;
  localparam logic [1:0] S_DONE   = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [1:0]        phase_q, phase_d;
  logic [1:0]        edge_q, edge_d;
  logic [1:0]        kind_q, kind_d;
  logic [1:0]        sa_q, sa_d, sb_q, sb_d, se_q, se_d;
  logic [1:0]        sg;
  logic              next_edge, finish;
  cap_e              cap;

  assign sg = {stat_i.acc_neg, stat_i.acc_zero};

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    phase_d   = phase_q;
    edge_d    = edge_q;
    kind_d    = kind_q;
    sa_d      = sa_q;
    sb_d      = sb_q;
    se_d      = se_q;
    next_edge = 1'b0;
    finish    = 1'b0;
    cap       = CAP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_INSIDE;
        end
      end
      S_INSIDE: begin
        step_d  = '0;
        phase_d = '0;
        edge_d  = '0;
        if (stat_i.end_inside) begin
          kind_d  = KIND_SKIP;
          state_d = S_DONE;
        end else begin
          kind_d  = KIND_CLEAR;
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        phase_d = phase_q + 2'd1;
        if (phase_q == PH_CHECK) begin
          step_d = step_q + 5'd1;
          case (step_q)
            STEP_SIDE_F: sa_d = sg;
            STEP_SIDE_S: sb_d = sg;
            STEP_SEG_E:  se_d = sg;
            STEP_SEG_N: begin
              if (sa_q != sb_q && se_q != sg) begin
                kind_d = KIND_CROSS;
                finish = 1'b1;
              end else if (stat_i.zero_len) begin
                if (stat_i.e_at_f && stat_i.m_pos) begin
                  kind_d = KIND_NEAR;
                  finish = 1'b1;
                end else begin
                  next_edge = 1'b1;
                end
              end else if (!stat_i.m_pos) begin
                next_edge = 1'b1;
              end
            end
            STEP_DOT, STEP_REM: begin
              if (stat_i.acc_neg) begin
                next_edge = 1'b1;
              end
            end
            STEP_LEN2:  cap = CAP_L2;
            STEP_CROSS: cap = CAP_CR;
            STEP_MARG2: cap = CAP_M2;
            STEP_LAST: begin
              if (stat_i.acc_neg) begin
                kind_d = KIND_NEAR;
                finish = 1'b1;
              end else begin
                next_edge = 1'b1;
              end
            end
            default: ;
          endcase
          // Advance to the next edge, or close after the fourth
          if (next_edge) begin
            step_d = '0;
            edge_d = edge_q + 2'd1;
            if (edge_q == 2'd3) begin
              finish = 1'b1;
            end
          end
          if (finish) begin
            state_d = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      phase_q <= '0;
      edge_q  <= '0;
      kind_q  <= KIND_CLEAR;
      sa_q    <= '0;
      sb_q    <= '0;
      se_q    <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      phase_q <= phase_d;
      edge_q  <= edge_d;
      kind_q  <= kind_d;
      sa_q    <= sa_d;
      sb_q    <= sb_d;
      se_q    <= se_d;
    end
  end

  assign ready_o = (state_q == S_IDLE);
  assign done_o  = (state_q == S_DONE) && out_free_i;
  assign kind_o  = kind_q;

  always_comb begin
    ctrl_o.busy     = (state_q == S_RUN);
    ctrl_o.phase    = phase_q;
    ctrl_o.edge_idx = edge_q;
    ctrl_o.uop      = step_uop(step_q);
    ctrl_o.cap      = cap;
  end

endmodule

### rtl/segment_obstacle_hit_test_core.sv
// Segment against obstacle rectangle hit test, top level; each multiply-accumulate step passes
// through its phases (operands, product, accumulate, check), and an edge runs 8 steps
// (orientation tests) or up to 25 (vertex-distance test); an endpoint strictly inside skips the edges.
// One obstacle is in work at a time: the next is accepted only after the result is registered.
// Reset (asynchronous, active low) clears the sequencer, output valid and the hit flag.
module segment_obstacle_hit_test_core import sohit_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  sohit_in_if.sink    item_i,
  sohit_out_if.source result_o
);

  dp_ctrl_t   ctrl;
  dp_stat_t   stat;
  logic       seq_ready, seq_done, out_free, accept;
  logic [1:0] kind;
  logic       out_valid_q, hit_seen_q, last_q, any_hit;
  out_item_t  out_q;

  assign accept   = item_i.valid && seq_ready;
  assign out_free = !out_valid_q || result_o.ready;
  assign any_hit  = hit_seen_q || kind[1];

  sohit_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .out_free_i (out_free),
    .stat_i     (stat),
    .ready_o    (seq_ready),
    .done_o     (seq_done),
    .kind_o     (kind),
    .ctrl_o     (ctrl)
  );

  sohit_dp u_dp (
    .clk_i  (clk_i),
    .load_i (accept),
    .item_i (item_i.data),
    .ctrl_i (ctrl),
    .stat_o (stat)
  );

  // Hold the list flag of the item in work and register the result
  always_ff @(posedge clk_i) begin
    if (accept) begin
      last_q <= item_i.data.last_rect;
    end
    if (seq_done) begin
      out_q.hit_kind  <= kind;
      out_q.any_hit   <= any_hit;
      out_q.list_done <= last_q;
    end
  end

  // Output valid and running hit flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      hit_seen_q  <= 1'b0;
    end else begin
      if (seq_done) begin
        out_valid_q <= 1'b1;
        hit_seen_q  <= last_q ? 1'b0 : any_hit;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign item_i.ready   = seq_ready;
  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_q;

endmodule

### tb/tb.sv
// Self-checking testbench for the segment against obstacle rectangle hit test.
module tb import sohit_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [191:0] wide_t;

  localparam int          N_RANDOM   = 1640;
  localparam int          HOLD_LEN   = 3000;
  localparam int          DRAIN_WAIT = 420;
  localparam int unsigned CYCLE_CAP  = 3_000_000;

  typedef struct {
    in_item_t   item;
    bit         typed;
    logic [1:0] kind;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  sohit_in_if  item_ch ();
  sohit_out_if result_ch ();

  segment_obstacle_hit_test_core DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_ch),
    .result_o (result_ch)
  );

  out_item_t   hit_queue[$];
  logic        list_hit_seen;
  int          n_errors;
  int          n_results;
  int unsigned n_cycles;
  bit          sending_done;

  // Clock and reset
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    clk_i  = 1'b0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Watchdog
  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CYCLE_CAP) begin
      $display("segment_obstacle_hit_test_core: mismatch");
      $finish;
    end
  end

  function automatic wide_t wx(logic [31:0] v);
    wide_t w;
    w = $signed(v);
    return w;
  endfunction

  function automatic int orient_sign(wide_t ax, wide_t az, wide_t bx, wide_t bz,
                                     wide_t px, wide_t pz);
    wide_t t;
    t = (bx - ax) * (pz - az) - (bz - az) * (px - ax);
    return (t < 0) ? -1 : ((t == 0) ? 0 : 1);
  endfunction

  // Exact vertex proximity: projection within the segment and distance below margin
  function automatic bit vertex_near(wide_t fx, wide_t fz, wide_t sx, wide_t sz,
                                     wide_t px, wide_t pz, wide_t m);
    wide_t d0, d1, dot, len2, crs;
    d0 = fx - sx;
    d1 = fz - sz;
    if (d0 == 0 && d1 == 0) return (px == fx) && (pz == fz) && (m > 0);
    if (m <= 0) return 1'b0;
    dot  = (px - fx) * (sx - fx) + (pz - fz) * (sz - fz);
    len2 = d0 * d0 + d1 * d1;
    if (dot < 0 || len2 < dot) return 1'b0;
    crs = (px - fx) * d1 - (pz - fz) * d0;
    return (crs * crs) < (m * m * len2);
  endfunction

  function automatic bit strictly_inside(wide_t x, wide_t z, wide_t x0, wide_t z0,
                                         wide_t x1, wide_t z1);
    return (x0 < x) && (z0 < z) && (x < x1) && (z < z1);
  endfunction

  // Predict one result and advance the running list flag
  function automatic out_item_t predict_hit(in_item_t it);
    out_item_t r;
    wide_t fx, fz, sx, sz, m, vx[4], vz[4];
    logic [1:0] kind;
    int n;
    fx = wx(it.first_x);
    fz = wx(it.first_z);
    sx = wx(it.second_x);
    sz = wx(it.second_z);
    m  = wx(it.clearance);
    vx[0] = wx(it.rect_min_x); vz[0] = wx(it.rect_min_z);
    vx[1] = wx(it.rect_max_x); vz[1] = wx(it.rect_min_z);
    vx[2] = wx(it.rect_max_x); vz[2] = wx(it.rect_max_z);
    vx[3] = wx(it.rect_min_x); vz[3] = wx(it.rect_max_z);
    kind = KIND_CLEAR;
    if (strictly_inside(fx, fz, vx[0], vz[0], vx[2], vz[2]) ||
        strictly_inside(sx, sz, vx[0], vz[0], vx[2], vz[2])) begin
      kind = KIND_SKIP;
    end else begin
      for (int i = 0; i < 4 && kind == KIND_CLEAR; i++) begin
        n = (i + 1) % 4;
        if (orient_sign(vx[i], vz[i], vx[n], vz[n], fx, fz) !=
            orient_sign(vx[i], vz[i], vx[n], vz[n], sx, sz) &&
            orient_sign(fx, fz, sx, sz, vx[i], vz[i]) !=
            orient_sign(fx, fz, sx, sz, vx[n], vz[n]))
          kind = KIND_CROSS;
        else if (vertex_near(fx, fz, sx, sz, vx[i], vz[i], m))
          kind = KIND_NEAR;
      end
    end
    r.hit_kind  = kind;
    r.any_hit   = list_hit_seen | (kind == KIND_CROSS || kind == KIND_NEAR);
    r.list_done = it.last_rect;
    list_hit_seen = it.last_rect ? 1'b0 : r.any_hit;
    return r;
  endfunction

  function automatic logic [31:0] q16(int v);
    return v <<< 16;
  endfunction

  function automatic in_item_t make_item(int fx, int fz, int sx, int sz, int m,
                                         int x0, int z0, int x1, int z1, bit last);
    in_item_t it;
    it.first_x    = q16(fx);
    it.first_z    = q16(fz);
    it.second_x   = q16(sx);
    it.second_z   = q16(sz);
    it.clearance  = q16(m);
    it.rect_min_x = q16(x0);
    it.rect_min_z = q16(z0);
    it.rect_max_x = q16(x1);
    it.rect_max_z = q16(z1);
    it.last_rect  = last;
    return it;
  endfunction

  // Coordinate draw: mostly a small grid, sometimes extremes or raw bits
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2:       return q16($urandom_range(0, 16) - 8) + ($urandom_range(0, 3) << 14);
      default: return q16($urandom_range(0, 16) - 8);
    endcase
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    logic [31:0] a, b;
    it.first_x  = rand_coord();
    it.first_z  = rand_coord();
    it.second_x = $urandom_range(0, 7) == 0 ? it.first_x : rand_coord();
    it.second_z = $urandom_range(0, 7) == 0 ? it.first_z : rand_coord();
    case ($urandom_range(0, 5))
      0:       it.clearance = $urandom;
      1:       it.clearance = 32'h0;
      2:       it.clearance = -q16($urandom_range(0, 3));
      default: it.clearance = q16($urandom_range(0, 3)) + ($urandom_range(0, 3) << 14);
    endcase
    // Ordered bounds most of the time, inverted or raw now and then
    a = rand_coord();
    b = rand_coord();
    if ($urandom_range(0, 7) != 0 && $signed(a) > $signed(b)) {a, b} = {b, a};
    it.rect_min_x = a;
    it.rect_max_x = b;
    a = rand_coord();
    b = rand_coord();
    if ($urandom_range(0, 7) != 0 && $signed(a) > $signed(b)) {a, b} = {b, a};
    it.rect_min_z = a;
    it.rect_max_z = b;
    it.last_rect  = ($urandom_range(0, 3) == 0);
    return it;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("result %0d: %s got %0d expected %0d", n_results, what, got, want);
    n_errors++;
  endtask

  // Offer one transaction after a random gap and hold it until taken
  task automatic send_item(in_item_t it, bit typed, logic [1:0] kind);
    out_item_t want;
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_ch.valid <= 1'b1;
    item_ch.data  <= it;
    do @(posedge clk_i); while (!(item_ch.valid && item_ch.ready));
    want = predict_hit(it);
    if (typed) want.hit_kind = kind;
    hit_queue.push_back(want);
  endtask

  // Stimulus
  initial begin
    stim_row_t rows[$];
    item_ch.valid  <= 1'b0;
    item_ch.data   <= '0;
    list_hit_seen  = 1'b0;
    n_errors       = 0;
    n_results      = 0;
    n_cycles       = 0;
    sending_done   = 1'b0;
    // endpoint strictly inside
    rows.push_back('{make_item(1, 1, 5, 5, 1, 0, 0, 4, 4, 0), 1, KIND_SKIP});
    // plain crossing
    rows.push_back('{make_item(-1, 2, 5, 2, 0, 0, 0, 4, 4, 0), 1, KIND_CROSS});
    // far away, closes the list
    rows.push_back('{make_item(10, 10, 12, 10, 0, 0, 0, 4, 4, 1), 1, KIND_CLEAR});
    // passes just below a corner
    rows.push_back('{make_item(-3, -1, 3, -1, 2, 0, 0, 4, 4, 0), 1, KIND_NEAR});
    // same with non-positive clearance
    rows.push_back('{make_item(-3, -1, 3, -1, -2, 0, 0, 4, 4, 0), 1, KIND_CLEAR});
    rows.push_back('{make_item(-3, -1, 3, -1, 0, 0, 0, 4, 4, 1), 1, KIND_CLEAR});
    // zero-length segment on a corner
    rows.push_back('{make_item(0, 0, 0, 0, 1, 0, 0, 4, 4, 1), 1, KIND_NEAR});
    rows.push_back('{make_item(0, 0, 0, 0, 0, 0, 0, 4, 4, 0), 1, KIND_CLEAR});
    // collinear with an edge, across its corners or lying within it
    rows.push_back('{make_item(-2, 0, 6, 0, 0, 0, 0, 4, 4, 0), 0, KIND_CLEAR});
    rows.push_back('{make_item(1, 0, 3, 0, 1, 0, 0, 4, 4, 1), 0, KIND_CLEAR});
    // inverted rectangle
    rows.push_back('{make_item(-1, 2, 5, 2, 1, 4, 4, 0, 0, 0), 0, KIND_CLEAR});
    rows.push_back('{make_item(2, 2, 2, 2, 1, 4, 4, 0, 0, 1), 0, KIND_CLEAR});
    // extremes of every field, then zeros and all-ones
    rows.push_back('{'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                      32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                      32'h7FFF_FFFF, 1'b0}, 0, KIND_CLEAR});
    rows.push_back('{'{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                      32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h7FFF_FFFF, 1'b1}, 0, KIND_CLEAR});
    rows.push_back('{'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0001,
                      32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                      32'h8000_0000, 1'b0}, 0, KIND_CLEAR});
    rows.push_back('{'{32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1}, 0, KIND_CLEAR});
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].kind);
    repeat (N_RANDOM) send_item(rand_item(), 1'b0, KIND_CLEAR);
    item_ch.valid <= 1'b0;
    sending_done = 1'b1;
  end

  // Result acceptance: random stalls, one long hold-off
  initial begin
    int stall;
    bit held;
    held = 1'b0;
    result_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (!held && n_results == 200) begin
        held = 1'b1;
        result_ch.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk_i);
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      result_ch.ready <= 1'b1;
      while (!(result_ch.valid && result_ch.ready)) @(posedge clk_i);
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      if (hit_queue.size() == 0) begin
        report_mismatch("unexpected transaction", 1, 0);
      end else begin
        want = hit_queue.pop_front();
        if (result_ch.data.hit_kind !== want.hit_kind)
          report_mismatch("hit_kind", result_ch.data.hit_kind, want.hit_kind);
        if (result_ch.data.any_hit !== want.any_hit)
          report_mismatch("any_hit", result_ch.data.any_hit, want.any_hit);
        if (result_ch.data.list_done !== want.list_done)
          report_mismatch("list_done", result_ch.data.list_done, want.list_done);
      end
      n_results++;
    end
  end

  // Drain and finish
  initial begin
    wait (sending_done);
    while (hit_queue.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("segment_obstacle_hit_test_core: match");
    end else begin
      $display("segment_obstacle_hit_test_core: mismatch");
    end
    $finish;
  end

endmodule

### segment_obstacle_hit_test_core.f
rtl/sohit_pkg.sv
rtl/sohit_if.sv
rtl/sohit_dp.sv
rtl/sohit_seq.sv
rtl/segment_obstacle_hit_test_core.sv
tb/tb.sv
